FILE: hdl/hbp_pkg.sv
// Shared types, constants and counter helpers for the hybrid branch predictor.
// Has no dependencies; every other file in hdl uses it by scoped names.
package hbp_pkg;

  // Table sizing limits.
  localparam int BIMODAL_ADDR_MAX = 12;
  localparam int GSHARE_ADDR_MAX  = 12;
  localparam int CHOOSER_ADDR_MAX = 10;
  localparam int HISTORY_MAX      = 12;

  // Both counter tables share one memory; the top address bit selects the table.
  localparam int TBL_IDX_W = (BIMODAL_ADDR_MAX > GSHARE_ADDR_MAX) ?
                             BIMODAL_ADDR_MAX : GSHARE_ADDR_MAX;
  localparam int CTR_AW    = TBL_IDX_W + 1;
  localparam int CTR_DEPTH = 1 << CTR_AW;
  localparam int CHS_DEPTH = 1 << CHOOSER_ADDR_MAX;
  localparam int CLR_W     = (CTR_AW > CHOOSER_ADDR_MAX) ? CTR_AW : CHOOSER_ADDR_MAX;

  localparam int CTR_W = 3;
  localparam int CHS_W = 2;
  localparam logic [CTR_W-1:0] CTR_MID   = 3'd4;
  localparam logic [CTR_W-1:0] CTR_TOP   = 3'd7;
  localparam logic [CHS_W-1:0] CHS_TOP   = 2'd3;
  localparam logic [CHS_W-1:0] CHS_RESET = 2'd1;

  // Configuration register map and reset values.
  localparam int CFG_AW = 5;
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_BI_BITS  = 3'd1,
    REG_GS_BITS  = 3'd2,
    REG_HIST_BITS = 3'd3,
    REG_CH_BITS  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2,
    MODE_ALT     = 2'd3
  } mode_t;

  localparam logic [3:0] RST_BI_BITS   = 4'd12;
  localparam logic [3:0] RST_GS_BITS   = 4'd12;
  localparam logic [3:0] RST_HIST_BITS = 4'd8;
  localparam logic [3:0] RST_CH_BITS   = 4'd10;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] bi_bits;
    logic [3:0] gs_bits;
    logic [3:0] hist_bits;
    logic [3:0] ch_bits;
  } cfg_t;

  // Access request from the control logic to the table memories.
  typedef struct packed {
    logic                        ctr_rd_en;
    logic [CTR_AW-1:0]           ctr_rd_addr;
    logic                        ctr_wr_en;
    logic [CTR_AW-1:0]           ctr_wr_addr;
    logic [CTR_W-1:0]            ctr_wr_data;
    logic                        chs_rd_en;
    logic [CHOOSER_ADDR_MAX-1:0] chs_rd_addr;
    logic                        chs_wr_en;
    logic [CHOOSER_ADDR_MAX-1:0] chs_wr_addr;
    logic [CHS_W-1:0]            chs_wr_data;
  } tbl_req_t;

  // Limits a length field to the given maximum.
  function automatic logic [3:0] cap_len(logic [3:0] v, int limit);
    if (int'(v) > limit) begin
      return 4'(limit);
    end
    return v;
  endfunction

  // Three-bit saturating counter step.
  function automatic logic [CTR_W-1:0] train_ctr(logic [CTR_W-1:0] c, logic taken);
    if (taken) begin
      return (c < CTR_TOP) ? c + 3'd1 : c;
    end
    return (c != '0) ? c - 3'd1 : c;
  endfunction

  // Chooser step: toward gshare when only gshare was right, toward bimodal
  // when only bimodal was right.
  function automatic logic [CHS_W-1:0] train_chs(logic [CHS_W-1:0] c, logic bi_ok,
                                                 logic g_ok);
    if (bi_ok && !g_ok && c != '0) begin
      return c - 2'd1;
    end
    if (g_ok && !bi_ok && c < CHS_TOP) begin
      return c + 2'd1;
    end
    return c;
  endfunction

endpackage

FILE: hdl/hbp_cfg_regs.sv
// Configuration register bank of the hybrid branch predictor, APB-style access.
// Depends on hbp_pkg for the register map and reset values.
module hbp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hbp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hbp_pkg::cfg_t              cfg
);

  hbp_pkg::cfg_t     cfg_r;
  hbp_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign reg_idx = hbp_pkg::reg_idx_t'(paddr[hbp_pkg::CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= hbp_pkg::MODE_HYBRID;
      cfg_r.bi_bits   <= hbp_pkg::RST_BI_BITS;
      cfg_r.gs_bits   <= hbp_pkg::RST_GS_BITS;
      cfg_r.hist_bits <= hbp_pkg::RST_HIST_BITS;
      cfg_r.ch_bits   <= hbp_pkg::RST_CH_BITS;
    end else if (wr_en) begin
      unique case (reg_idx)
        hbp_pkg::REG_MODE:      cfg_r.mode      <= hbp_pkg::mode_t'(pwdata[1:0]);
        hbp_pkg::REG_BI_BITS:   cfg_r.bi_bits   <= pwdata[3:0];
        hbp_pkg::REG_GS_BITS:   cfg_r.gs_bits   <= pwdata[3:0];
        hbp_pkg::REG_HIST_BITS: cfg_r.hist_bits <= pwdata[3:0];
        hbp_pkg::REG_CH_BITS:   cfg_r.ch_bits   <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      hbp_pkg::REG_MODE:      prdata = {30'd0, cfg_r.mode};
      hbp_pkg::REG_BI_BITS:   prdata = {28'd0, cfg_r.bi_bits};
      hbp_pkg::REG_GS_BITS:   prdata = {28'd0, cfg_r.gs_bits};
      hbp_pkg::REG_HIST_BITS: prdata = {28'd0, cfg_r.hist_bits};
      hbp_pkg::REG_CH_BITS:   prdata = {28'd0, cfg_r.ch_bits};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: hdl/hbp_tables.sv
// Counter memory (bimodal and gshare halves) and chooser memory, with the
// clearing sweep after reset. Depends on hbp_pkg for sizes and the request struct.
module hbp_tables (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hbp_pkg::tbl_req_t           req,
  output logic [hbp_pkg::CTR_W-1:0]   ctr_rd_data,
  output logic [hbp_pkg::CHS_W-1:0]   chs_rd_data,
  output logic                        clearing
);

  logic [hbp_pkg::CTR_W-1:0] ctr_mem [hbp_pkg::CTR_DEPTH];
  logic [hbp_pkg::CHS_W-1:0] chs_mem [hbp_pkg::CHS_DEPTH];

  logic [hbp_pkg::CLR_W-1:0] clr_r;
  logic                      clr_busy_r;
  logic                      clr_ctr_hit;
  logic                      clr_chs_hit;
  logic [hbp_pkg::CTR_W-1:0] ctr_rd_r;
  logic [hbp_pkg::CHS_W-1:0] chs_rd_r;

  assign clearing    = clr_busy_r;
  assign ctr_rd_data = ctr_rd_r;
  assign chs_rd_data = chs_rd_r;
  assign clr_ctr_hit = {1'b0, clr_r} < (hbp_pkg::CLR_W + 1)'(hbp_pkg::CTR_DEPTH);
  assign clr_chs_hit = {1'b0, clr_r} < (hbp_pkg::CLR_W + 1)'(hbp_pkg::CHS_DEPTH);

  // The sweep writes one entry of each memory per cycle until that memory is covered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_r <= clr_r + (hbp_pkg::CLR_W)'(1);
      if (&clr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      if (clr_ctr_hit) begin
        ctr_mem[clr_r[hbp_pkg::CTR_AW-1:0]] <= hbp_pkg::CTR_MID;
      end
    end else if (req.ctr_wr_en) begin
      ctr_mem[req.ctr_wr_addr] <= req.ctr_wr_data;
    end
    if (req.ctr_rd_en) begin
      ctr_rd_r <= ctr_mem[req.ctr_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      if (clr_chs_hit) begin
        chs_mem[clr_r[hbp_pkg::CHOOSER_ADDR_MAX-1:0]] <= hbp_pkg::CHS_RESET;
      end
    end else if (req.chs_wr_en) begin
      chs_mem[req.chs_wr_addr] <= req.chs_wr_data;
    end
    if (req.chs_rd_en) begin
      chs_rd_r <= chs_mem[req.chs_rd_addr];
    end
  end

endmodule

FILE: hdl/hybrid_branch_predictor_core.sv
// Hybrid (bimodal + gshare with chooser) branch predictor; uses hbp_pkg,
// hbp_cfg_regs and hbp_tables. A request accepted at a clock edge goes through
// the second-read and update states; out_valid then strobes its result from a
// register. No new request is accepted until the last one has finished the two
// reads of the shared counter memory and its write-back. After reset the memories
// are cleared in one pass over the counter memory depth (8192), with busy high.
module hybrid_branch_predictor_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel.
  input  logic                       start,
  output logic                       busy,
  input  logic [31:0]                in_branch_address,
  input  logic                       in_outcome_taken,
  // Result channel; the receiver always takes the result.
  output logic                       out_valid,
  output logic                       out_predicted_taken,
  output logic                       out_mispredicted,
  output logic                       out_used_gshare,
  output logic [31:0]                out_branch_total,
  output logic [31:0]                out_miss_total,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hbp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int BI = hbp_pkg::BIMODAL_ADDR_MAX;
  localparam int GS = hbp_pkg::GSHARE_ADDR_MAX;
  localparam int CH = hbp_pkg::CHOOSER_ADDR_MAX;
  localparam int HM = hbp_pkg::HISTORY_MAX;
  localparam int TW = hbp_pkg::TBL_IDX_W;

  // Sequencer: the clear pass, then idle / second read / update per request.
  typedef enum logic [3:0] {
    S_CLEAR   = 4'b0001,
    S_IDLE    = 4'b0010,
    S_READ_GS = 4'b0100,
    S_UPDATE  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  hbp_pkg::cfg_t     cfg;
  hbp_pkg::tbl_req_t tbl_req;
  logic [hbp_pkg::CTR_W-1:0] ctr_rd_data;
  logic [hbp_pkg::CHS_W-1:0] chs_rd_data;
  logic                      clearing;

  hbp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hbp_tables u_tables (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (tbl_req),
    .ctr_rd_data (ctr_rd_data),
    .chs_rd_data (chs_rd_data),
    .clearing    (clearing)
  );

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Effective table widths and history length. The history can never be
  // longer than the gshare index it is folded into.
  logic [3:0] m2;
  logic [3:0] m1;
  logic [3:0] k;
  logic [3:0] n;

  assign m2 = hbp_pkg::cap_len(cfg.bi_bits, BI);
  assign m1 = hbp_pkg::cap_len(cfg.gs_bits, GS);
  assign k  = hbp_pkg::cap_len(cfg.ch_bits, CH);
  assign n  = hbp_pkg::cap_len(hbp_pkg::cap_len(cfg.hist_bits, int'(m1)), HM);

  logic [HM-1:0] hist_r;
  logic [HM-1:0] hist_nxt;
  logic [HM-1:0] hist_m;
  logic [31:0]   hist_sh;
  logic [29:0]   word;
  logic [BI-1:0] bi_idx;
  logic [GS-1:0] g_idx;
  logic [CH-1:0] ch_idx;

  // The history is read masked to the current length, so a shortened history
  // drops its upper bits; the history lands in the top bits of the gshare index.
  assign hist_m  = hist_r & ~({HM{1'b1}} << n);
  assign hist_sh = 32'(hist_m) << (m1 - n);
  assign word    = in_branch_address[31:2];
  assign bi_idx  = word[BI-1:0] & ~({BI{1'b1}} << m2);
  assign g_idx   = (word[GS-1:0] ^ hist_sh[GS-1:0]) & ~({GS{1'b1}} << m1);
  assign ch_idx  = word[CH-1:0] & ~({CH{1'b1}} << k);

  // Request context held while the request walks through the sequencer.
  logic [hbp_pkg::CTR_AW-1:0] bi_addr_r;
  logic [hbp_pkg::CTR_AW-1:0] g_addr_r;
  logic [CH-1:0]              ch_idx_r;
  logic                       taken_r;
  logic [hbp_pkg::CTR_W-1:0]  bi_cnt_r;
  logic [hbp_pkg::CHS_W-1:0]  chs_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      bi_addr_r <= {1'b0, TW'(bi_idx)};
      g_addr_r  <= {1'b1, TW'(g_idx)};
      ch_idx_r  <= ch_idx;
      taken_r   <= in_outcome_taken;
    end
    if (state_r == S_READ_GS) begin
      bi_cnt_r <= ctr_rd_data;
      chs_r    <= chs_rd_data;
    end
  end

  // Prediction and training. In the update cycle the counter memory presents
  // the gshare counter; the bimodal counter and chooser were captured before.
  logic bi_pred;
  logic g_pred;
  logic use_g;
  logic pred;
  logic miss;
  logic hybrid;

  assign hybrid  = cfg.mode[1];
  assign bi_pred = bi_cnt_r >= hbp_pkg::CTR_MID;
  assign g_pred  = ctr_rd_data >= hbp_pkg::CTR_MID;
  assign use_g   = (cfg.mode == hbp_pkg::MODE_BIMODAL) ? 1'b0 :
                   (cfg.mode == hbp_pkg::MODE_GSHARE)  ? 1'b1 : chs_r[1];
  assign pred    = use_g ? g_pred : bi_pred;
  assign miss    = pred != taken_r;

  // The true outcome enters at the top of the active history.
  always_comb begin
    hist_nxt = hist_r;
    if (state_r == S_UPDATE && cfg.mode != hbp_pkg::MODE_BIMODAL) begin
      if (n != 4'd0) begin
        hist_nxt = (hist_m >> 1) | (HM'(taken_r) << (n - 4'd1));
      end else begin
        hist_nxt = '0;
      end
    end
  end

  // Memory traffic: bimodal and chooser read at acceptance, gshare read in the
  // second-read state, one write-back of the chosen counter (and of the chooser
  // when hybrid) at update. Requests never overlap, so no forwarding is needed.
  always_comb begin
    tbl_req             = '0;
    tbl_req.chs_rd_addr = ch_idx;
    tbl_req.chs_wr_addr = ch_idx_r;
    tbl_req.chs_wr_data = hbp_pkg::train_chs(chs_r, bi_pred == taken_r, g_pred == taken_r);
    tbl_req.ctr_wr_addr = use_g ? g_addr_r : bi_addr_r;
    tbl_req.ctr_wr_data = hbp_pkg::train_ctr(use_g ? ctr_rd_data : bi_cnt_r, taken_r);
    tbl_req.ctr_rd_addr = {1'b0, TW'(bi_idx)};
    if (accept) begin
      tbl_req.ctr_rd_en = 1'b1;
      tbl_req.chs_rd_en = 1'b1;
    end
    if (state_r == S_READ_GS) begin
      tbl_req.ctr_rd_en   = 1'b1;
      tbl_req.ctr_rd_addr = g_addr_r;
    end
    if (state_r == S_UPDATE) begin
      tbl_req.ctr_wr_en = 1'b1;
      tbl_req.chs_wr_en = hybrid;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   state_nxt = clearing ? S_CLEAR : S_IDLE;
      S_IDLE:    state_nxt = accept ? S_READ_GS : S_IDLE;
      S_READ_GS: state_nxt = S_UPDATE;
      S_UPDATE:  state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  // Result registers. The running totals double as the result's total fields.
  logic        out_valid_r;
  logic        pred_r;
  logic        miss_r;
  logic        used_g_r;
  logic [31:0] branch_total_r;
  logic [31:0] miss_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      hist_r         <= '0;
      out_valid_r    <= 1'b0;
      branch_total_r <= '0;
      miss_total_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= (state_r == S_UPDATE);
      if (state_r == S_UPDATE) begin
        branch_total_r <= branch_total_r + 32'd1;
        if (miss) begin
          miss_total_r <= miss_total_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPDATE) begin
      pred_r   <= pred;
      miss_r   <= miss;
      used_g_r <= use_g;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = pred_r;
  assign out_mispredicted    = miss_r;
  assign out_used_gshare     = used_g_r;
  assign out_branch_total    = branch_total_r;
  assign out_miss_total      = miss_total_r;

`ifndef NO_ASSERTIONS
  // A result only follows an update cycle.
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_UPDATE))
    else $error("result strobe without an update cycle");

  // Requests are handled one at a time, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // The miss flag agrees with the prediction and the held outcome.
  a_miss_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mispredicted == (out_predicted_taken ^ taken_r)))
    else $error("miss flag disagrees with prediction and outcome");

  // The chooser is written only in hybrid mode during an update.
  a_chooser_write: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.chs_wr_en |-> (state_r == S_UPDATE && hybrid))
    else $error("chooser written outside a hybrid update");

  // Bimodal-only updates leave the global history alone.
  a_hist_bimodal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && cfg.mode == hbp_pkg::MODE_BIMODAL) |=> $stable(hist_r))
    else $error("history changed in bimodal mode");
`endif

endmodule

FILE: bench/hybrid_branch_predictor_core_tb.sv
// Self-checking testbench for hybrid_branch_predictor_core: directed table, then random phases.
// Depends on hbp_pkg for the register indexes, the mode codes and the table size limits.
module hybrid_branch_predictor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbp_pkg::*;

  // One predicted outcome of a resolved branch, field for field as the block reports it.
  typedef struct packed {
    logic        pred;
    logic        miss;
    logic        used_g;
    logic [31:0] total;
    logic [31:0] misses;
  } branch_res_t;

  // A row of the directed table is either a register write or a branch request.
  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [3:0]  reg_val;
    logic [31:0] addr;
    logic        taken;
    logic        typed;
    branch_res_t res;
  } plan_row_t;

  localparam int POOL_SIZE = 8;
  localparam int PHASES    = 10;
  localparam int PHASE_REQS = 110;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [31:0]         in_branch_address;
  logic                in_outcome_taken;
  logic                out_valid;
  logic                out_predicted_taken;
  logic                out_mispredicted;
  logic                out_used_gshare;
  logic [31:0]         out_branch_total;
  logic [31:0]         out_miss_total;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  hybrid_branch_predictor_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_branch_address   (in_branch_address),
    .in_outcome_taken    (in_outcome_taken),
    .out_valid           (out_valid),
    .out_predicted_taken (out_predicted_taken),
    .out_mispredicted    (out_mispredicted),
    .out_used_gshare     (out_used_gshare),
    .out_branch_total    (out_branch_total),
    .out_miss_total      (out_miss_total),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Shadow copy of the predictor: both counter tables, the chooser, the global
  // history, the two running tallies and the five configuration registers.
  logic [2:0]  bimodal_ctr [0:(1<<BIMODAL_ADDR_MAX)-1];
  logic [2:0]  gshare_ctr  [0:(1<<GSHARE_ADDR_MAX)-1];
  logic [1:0]  chooser_ctr [0:(1<<CHOOSER_ADDR_MAX)-1];
  int          ghist;
  logic [31:0] branch_tally;
  logic [31:0] miss_tally;
  mode_t       cfg_mode;
  logic [3:0]  cfg_bi;
  logic [3:0]  cfg_gs;
  logic [3:0]  cfg_hist;
  logic [3:0]  cfg_ch;

  // Outcomes still owed by the block, oldest first.
  branch_res_t pending_outcomes[$];
  int          errors;
  plan_row_t   plan[$];

  // Random branch pool: each entry is either strongly biased or periodic, so
  // that the counters saturate and the chooser gets pushed both ways.
  logic [31:0] pool_addr   [POOL_SIZE];
  logic        pool_bias   [POOL_SIZE];
  int          pool_period [POOL_SIZE];
  int          pool_visits [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: the slowest correct run is well under a fifth of this.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int lmask(int bits);
    return (1 << bits) - 1;
  endfunction

  function automatic int clip(int v, int limit);
    return (v > limit) ? limit : v;
  endfunction

  function automatic logic [2:0] sat3(logic [2:0] c, logic up);
    if (up) begin
      return (c == 3'd7) ? c : c + 3'd1;
    end
    return (c == 3'd0) ? c : c - 3'd1;
  endfunction

  // Restores the shadow state to what the block holds after reset.
  function automatic void reset_shadow();
    for (int i = 0; i < (1 << BIMODAL_ADDR_MAX); i++) bimodal_ctr[i] = 3'd4;
    for (int i = 0; i < (1 << GSHARE_ADDR_MAX); i++) gshare_ctr[i] = 3'd4;
    for (int i = 0; i < (1 << CHOOSER_ADDR_MAX); i++) chooser_ctr[i] = 2'd1;
    ghist        = 0;
    branch_tally = '0;
    miss_tally   = '0;
    cfg_mode     = MODE_HYBRID;
    cfg_bi       = 4'd12;
    cfg_gs       = 4'd12;
    cfg_hist     = 4'd8;
    cfg_ch       = 4'd10;
  endfunction

  function automatic void shadow_write(reg_idx_t r, logic [3:0] v);
    case (r)
      REG_MODE:      cfg_mode = mode_t'(v[1:0]);
      REG_BI_BITS:   cfg_bi = v;
      REG_GS_BITS:   cfg_gs = v;
      REG_HIST_BITS: cfg_hist = v;
      REG_CH_BITS:   cfg_ch = v;
      default: ;
    endcase
  endfunction

  // Predicts one resolved branch and trains the shadow state exactly as the
  // block is meant to.
  function automatic branch_res_t predict_branch(logic [31:0] addr, logic taken);
    int          word;
    int          m2;
    int          m1;
    int          k;
    int          n;
    int          hist;
    int          bi_idx;
    int          g_idx;
    int          ch_idx;
    logic        bi_pred;
    logic        g_pred;
    logic        use_g;
    logic        bi_ok;
    logic        g_ok;
    branch_res_t r;
    word   = int'(addr[31:2]);
    m2     = clip(int'(cfg_bi), BIMODAL_ADDR_MAX);
    m1     = clip(int'(cfg_gs), GSHARE_ADDR_MAX);
    k      = clip(int'(cfg_ch), CHOOSER_ADDR_MAX);
    n      = clip(clip(int'(cfg_hist), m1), HISTORY_MAX);
    hist   = ghist & lmask(n);
    bi_idx = word & lmask(m2);
    g_idx  = ((word & lmask(m1)) ^ (hist << (m1 - n))) & lmask(m1);
    ch_idx = word & lmask(k);
    bi_pred = bimodal_ctr[bi_idx] >= 3'd4;
    g_pred  = gshare_ctr[g_idx] >= 3'd4;
    case (cfg_mode)
      MODE_BIMODAL: use_g = 1'b0;
      MODE_GSHARE:  use_g = 1'b1;
      default:      use_g = chooser_ctr[ch_idx] >= 2'd2;
    endcase
    r.pred   = use_g ? g_pred : bi_pred;
    r.miss   = r.pred != taken;
    r.used_g = use_g;
    branch_tally = branch_tally + 32'd1;
    if (r.miss) begin
      miss_tally = miss_tally + 32'd1;
    end
    r.total  = branch_tally;
    r.misses = miss_tally;
    if (use_g) begin
      gshare_ctr[g_idx] = sat3(gshare_ctr[g_idx], taken);
    end else begin
      bimodal_ctr[bi_idx] = sat3(bimodal_ctr[bi_idx], taken);
    end
    if (cfg_mode != MODE_BIMODAL) begin
      ghist = (n > 0) ? ((hist >> 1) | (int'(taken) << (n - 1))) : 0;
    end
    if (cfg_mode == MODE_HYBRID || cfg_mode == MODE_ALT) begin
      bi_ok = bi_pred == taken;
      g_ok  = g_pred == taken;
      if (bi_ok && !g_ok && chooser_ctr[ch_idx] != 2'd0) begin
        chooser_ctr[ch_idx] = chooser_ctr[ch_idx] - 2'd1;
      end else if (g_ok && !bi_ok && chooser_ctr[ch_idx] != 2'd3) begin
        chooser_ctr[ch_idx] = chooser_ctr[ch_idx] + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t req_row(logic [31:0] addr, logic taken);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_REQ;
    row.addr    = addr;
    row.taken   = taken;
    return row;
  endfunction

  // A request whose outcome is obvious enough to be written straight into the table.
  function automatic plan_row_t chk_row(logic [31:0] addr, logic taken, logic pred,
                                        logic miss, logic used_g, logic [31:0] total,
                                        logic [31:0] misses);
    plan_row_t row;
    row            = req_row(addr, taken);
    row.typed      = 1'b1;
    row.res.pred   = pred;
    row.res.miss   = miss;
    row.res.used_g = used_g;
    row.res.total  = total;
    row.res.misses = misses;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_t r, logic [3:0] v);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = r;
    row.reg_val = v;
    return row;
  endfunction

  // Mostly back-to-back requests, some short gaps and now and then a long one.
  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Index widths for a random phase lean on the edges: zero, the table
  // limit and the oversized all-ones code.
  function automatic logic [3:0] pick_width(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 4'd0;
    end
    if (r < 25) begin
      return 4'(limit);
    end
    if (r < 35) begin
      return 4'd15;
    end
    return 4'($urandom_range(1, 15));
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // All tasks below are entered just after a rising edge and leave just after one.
  // A request is offered at the edge and taken at the first later edge with busy
  // low; busy is looked at on the falling edge so that no race with the block's
  // own flops can arise. The expected outcome is worked out in the same step.
  task automatic send_request(logic [31:0] addr, logic taken, logic typed,
                              branch_res_t typed_res);
    branch_res_t r;
    in_branch_address <= addr;
    in_outcome_taken  <= taken;
    start             <= 1'b1;
    do begin
      @(negedge clk);
    end while (busy);
    r = predict_branch(addr, taken);
    pending_outcomes.push_back(typed ? typed_res : r);
    @(posedge clk);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops the request stream, lets every owed outcome arrive and then lets the
  // clock run on idle before returning.
  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; the register changes at the access edge with
  // pready high, after which the port is driven idle before the task returns.
  task automatic write_reg(reg_idx_t r, logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
    end while (!pready);
    @(posedge clk);
    shadow_write(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Every result strobe is matched against the oldest owed outcome. Sampling
  // on the falling edge keeps the check clear of the block's clock edge.
  always @(negedge clk) begin : result_monitor
    branch_res_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, actual total %0h", $time,
                 out_branch_total);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("predicted_taken", 32'(want.pred), 32'(out_predicted_taken));
        check_field("mispredicted", 32'(want.miss), 32'(out_mispredicted));
        check_field("used_gshare", 32'(want.used_g), 32'(out_used_gshare));
        check_field("branch_total", want.total, out_branch_total);
        check_field("miss_total", want.misses, out_miss_total);
      end
    end
  end

  initial begin : stimulus
    logic [3:0] mode_code;
    logic [3:0] bi_w;
    logic [3:0] gs_w;
    logic [3:0] hist_w;
    logic [3:0] ch_w;
    logic       quiet;
    logic [31:0] addr;
    logic        taken;
    int          sel;
    int          r;

    errors            = 0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_branch_address = '0;
    in_outcome_taken  = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    reset_shadow();

    // Directed part. The first rows run on the reset settings: the chooser
    // starts weakly on bimodal and every counter starts weakly taken.
    plan.push_back(chk_row(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 32'd1, 32'd0));
    plan.push_back(chk_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd2, 32'd1));
    plan.push_back(req_row(32'hFFFF_FFFC, 1'b0));
    // Gshare only: no gshare counter has been trained yet, so it says taken.
    plan.push_back(cfg_row(REG_MODE, 4'(MODE_GSHARE)));
    plan.push_back(chk_row(32'h0000_0010, 1'b0, 1'b1, 1'b1, 1'b1, 32'd4, 32'd2));
    plan.push_back(req_row(32'h0000_0010, 1'b0));
    plan.push_back(req_row(32'h0000_0010, 1'b0));
    // Bimodal only: history and chooser must hold still.
    plan.push_back(cfg_row(REG_MODE, 4'(MODE_BIMODAL)));
    plan.push_back(req_row(32'h0000_0020, 1'b1));
    plan.push_back(req_row(32'h0000_0020, 1'b0));
    // The spare mode code behaves as hybrid.
    plan.push_back(cfg_row(REG_MODE, 4'(MODE_ALT)));
    plan.push_back(req_row(32'h0000_0040, 1'b0));
    plan.push_back(req_row(32'h0000_0040, 1'b0));
    plan.push_back(req_row(32'h0000_0040, 1'b1));
    // Shortened history: stale upper bits must be masked off.
    plan.push_back(cfg_row(REG_HIST_BITS, 4'd3));
    plan.push_back(req_row(32'h0000_0080, 1'b1));
    plan.push_back(req_row(32'h0000_0084, 1'b0));
    // Zero-width indexes and an empty history.
    plan.push_back(cfg_row(REG_BI_BITS, 4'd0));
    plan.push_back(cfg_row(REG_GS_BITS, 4'd0));
    plan.push_back(cfg_row(REG_CH_BITS, 4'd0));
    plan.push_back(cfg_row(REG_HIST_BITS, 4'd0));
    plan.push_back(req_row(32'hDEAD_BEEF, 1'b1));
    plan.push_back(req_row(32'h1234_5678, 1'b0));
    plan.push_back(req_row(32'h0000_0000, 1'b1));
    // Oversized codes saturate at the table limits.
    plan.push_back(cfg_row(REG_BI_BITS, 4'd15));
    plan.push_back(cfg_row(REG_GS_BITS, 4'd15));
    plan.push_back(cfg_row(REG_CH_BITS, 4'd15));
    plan.push_back(cfg_row(REG_HIST_BITS, 4'd15));
    plan.push_back(req_row(32'hFFFF_FFFF, 1'b1));
    plan.push_back(req_row(32'hAAAA_AAA8, 1'b0));
    plan.push_back(req_row(32'h5555_5554, 1'b1));
    // History longer than the gshare index is cut to the index width.
    plan.push_back(cfg_row(REG_GS_BITS, 4'd4));
    plan.push_back(cfg_row(REG_HIST_BITS, 4'd12));
    plan.push_back(req_row(32'h0000_003C, 1'b1));
    plan.push_back(req_row(32'h0000_003C, 1'b1));
    plan.push_back(req_row(32'h0000_003C, 1'b0));
    plan.push_back(cfg_row(REG_MODE, 4'(MODE_HYBRID)));

    // Reset once, then wait out the memory clearing pass (busy stays high).
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    do begin
      @(negedge clk);
    end while (busy);
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send_request(plan[i].addr, plan[i].taken, plan[i].typed, plan[i].res);
        hold_off(pick_gap(1'b0));
      end
    end

    // Random phases. Each one starts idle, writes all five registers, builds a
    // fresh pool of branches and then streams requests. The first phases pin
    // the largest, oversized and zero settings; the rest pick at random.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        mode_code = 4'(MODE_HYBRID);
        bi_w = 4'(BIMODAL_ADDR_MAX);
        gs_w = 4'(GSHARE_ADDR_MAX);
        hist_w = 4'(HISTORY_MAX);
        ch_w = 4'(CHOOSER_ADDR_MAX);
      end else if (p == 1) begin
        mode_code = 4'(MODE_ALT);
        bi_w = 4'd15;
        gs_w = 4'd15;
        hist_w = 4'd15;
        ch_w = 4'd15;
      end else if (p == 2) begin
        mode_code = 4'(MODE_GSHARE);
        bi_w = 4'd0;
        gs_w = 4'd0;
        hist_w = 4'd0;
        ch_w = 4'd0;
      end else begin
        r = $urandom_range(0, 99);
        mode_code = (r < 50) ? 4'(MODE_HYBRID) : 4'($urandom_range(0, 3));
        bi_w = pick_width(BIMODAL_ADDR_MAX);
        gs_w = pick_width(GSHARE_ADDR_MAX);
        hist_w = pick_width(HISTORY_MAX);
        ch_w = pick_width(CHOOSER_ADDR_MAX);
      end
      drain();
      write_reg(REG_MODE, mode_code);
      write_reg(REG_BI_BITS, bi_w);
      write_reg(REG_GS_BITS, gs_w);
      write_reg(REG_HIST_BITS, hist_w);
      write_reg(REG_CH_BITS, ch_w);

      for (int j = 0; j < POOL_SIZE; j++) begin
        pool_addr[j]   = $urandom();
        pool_bias[j]   = 1'($urandom_range(0, 1));
        pool_period[j] = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 4) : 0;
        pool_visits[j] = 0;
      end

      // Some phases run with no gaps on the request side but the rare full drain.
      quiet = ($urandom_range(0, 3) == 0);
      for (int q = 0; q < PHASE_REQS; q++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          sel = $urandom_range(0, POOL_SIZE - 1);
          addr = pool_addr[sel];
          if (pool_period[sel] != 0) begin
            // Periodic branch: the pattern only gshare can learn.
            taken = (pool_visits[sel] % pool_period[sel]) != 0;
          end else begin
            taken = ($urandom_range(0, 99) < 85) ? pool_bias[sel] : ~pool_bias[sel];
          end
          pool_visits[sel]++;
        end else begin
          addr  = $urandom();
          taken = 1'($urandom_range(0, 1));
        end
        send_request(addr, taken, 1'b0, '0);
        // Once in a while the sender waits until every outcome is back.
        if ($urandom_range(0, 199) == 0) begin
          drain();
        end else begin
          hold_off(pick_gap(quiet));
        end
      end
    end

    // Let the last outcomes arrive, then give stray strobes a chance to show.
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
